[design/dfir2_pkg.sv]
// ----------------------------------------------------------------------------
// dfir2_pkg
// Shared widths, register index codes and types of the decimating FIR unit.
// ----------------------------------------------------------------------------
package dfir2_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int ACC_W       = 35;
   localparam int TAP_COUNT_W = 4;
   localparam int COEF_REG_W  = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TAPS_LO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TAPS_HI = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   // control that travels with one operand pair into the MAC
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

[design/dfir2_if.sv]
// ----------------------------------------------------------------------------
// dfir2 channel interfaces
// Valid/ready channels for samples, filtered results and register writes.
// ----------------------------------------------------------------------------
interface dfir2_req_if;
   logic                 valid;
   logic                 ready;
   dfir2_pkg::sample_type sample;
   logic                 last_in;
   modport source (output valid, output sample, output last_in, input ready);
   modport sink   (input valid, input sample, input last_in, output ready);
endinterface

interface dfir2_rsp_if;
   logic               valid;
   logic               ready;
   dfir2_pkg::acc_type filtered_value;
   logic               last_out;
   modport source (output valid, output filtered_value, output last_out, input ready);
   modport sink   (input valid, input filtered_value, input last_out, output ready);
endinterface

interface dfir2_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dfir2_pkg::CSR_IDX_W-1:0]     index;
   logic [dfir2_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/dfir2_mac.sv]
// ----------------------------------------------------------------------------
// dfir2_mac
// Shared two-stage multiply-accumulate unit: register the product, then add.
// ----------------------------------------------------------------------------
module dfir2_mac (
   input  logic                   clock,
   input  logic                   reset,
   input  dfir2_pkg::mac_ctl_type ctl,
   input  dfir2_pkg::coef_type    coef,
   input  dfir2_pkg::sample_type  smp,
   output dfir2_pkg::acc_type     acc,
   output logic                   done
);

   dfir2_pkg::prod_type    prod_ff;
   dfir2_pkg::mac_ctl_type pctl_ff;
   dfir2_pkg::acc_type     acc_ff;
   dfir2_pkg::acc_type     acc_in;
   dfir2_pkg::acc_type     prod_ext;
   logic                   done_ff;

   // multiply stage
   always_ff @(posedge clock) begin
      prod_ff <= coef * smp;
      if (reset) begin
         pctl_ff <= '0;
      end else begin
         pctl_ff <= ctl;
      end
   end

   // accumulate stage: first product restarts the sum
   assign prod_ext = dfir2_pkg::acc_type'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (pctl_ff.valid) begin
         acc_in = pctl_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= pctl_ff.valid && pctl_ff.last;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

[design/decimating_fir_by_two_unit.sv]
// ----------------------------------------------------------------------------
// decimating_fir_by_two_unit
// Vector FIR filter with decimation by two and tail flush on the last sample.
// ----------------------------------------------------------------------------
// A sample is taken only while the unit is idle. An even-position sample
// yields one result; the last sample of a vector also yields the tail results
// (zeros assumed after it), and history and phase then clear. Each result
// runs the taps it needs through one shared multiplier-accumulator, one tap a
// cycle: a result at offset d issues taps d up to the tap count less one, then
// passes the MAC's product and accumulate registers and is loaded into the
// output register. An odd-position sample that is not last yields no result
// and leaves the unit idle. The output register lets the unit take the next
// sample while a result still waits downstream. Coefficients reset to zero and
// the tap count to one.
module decimating_fir_by_two_unit #(
   parameter int MAX_TAPS = 8
) (
   input  logic      clock,
   input  logic      reset,
   dfir2_req_if.sink   req_chan,
   dfir2_rsp_if.source rsp_chan,
   dfir2_csr_if.sink   csr_chan
);

   localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int LW = $clog2(MAX_TAPS + 1);
   localparam int CW = LW + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]                              state_ff, state_in;
   logic [dfir2_pkg::TAP_COUNT_W-1:0]       tap_count_ff;
   logic [dfir2_pkg::COEF_REG_W-1:0]        coef_lo_ff, coef_hi_ff;
   logic [2*dfir2_pkg::COEF_REG_W-1:0]      coef_all;
   dfir2_pkg::coef_type                     tap_arr [MAX_TAPS];
   dfir2_pkg::sample_type                   win_ff [MAX_TAPS];
   dfir2_pkg::sample_type                   hist_ff [MAX_TAPS-1];
   logic                                    parity_ff;
   logic                                    last_ff;
   logic [IW-1:0]                           d_ff, j_ff;
   logic [LW-1:0]                           len;
   logic                                    req_fire;
   logic                                    more_tail;
   logic                                    j_at_end;
   logic                                    out_free;
   dfir2_pkg::mac_ctl_type                  mac_ctl;
   dfir2_pkg::acc_type                      mac_acc;
   logic                                    mac_done;
   logic                                    rsp_valid_ff;
   dfir2_pkg::acc_type                      rsp_value_ff;
   logic                                    rsp_last_ff;

   // configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= dfir2_pkg::TAP_COUNT_W'(1);
         coef_lo_ff   <= '0;
         coef_hi_ff   <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            dfir2_pkg::CSR_TAP_COUNT: begin
               tap_count_ff <= csr_chan.data[dfir2_pkg::TAP_COUNT_W-1:0];
            end
            dfir2_pkg::CSR_COEF_TAPS_LO: begin
               coef_lo_ff <= csr_chan.data;
            end
            dfir2_pkg::CSR_COEF_TAPS_HI: begin
               coef_hi_ff <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

   // tap table and clamped tap count
   assign coef_all = {coef_hi_ff, coef_lo_ff};

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
      assign tap_arr[k] = coef_all[k*dfir2_pkg::COEF_W +: dfir2_pkg::COEF_W];
   end

   always_comb begin
      if (tap_count_ff == '0) begin
         len = LW'(1);
      end else if (tap_count_ff > dfir2_pkg::TAP_COUNT_W'(MAX_TAPS)) begin
         len = LW'(MAX_TAPS);
      end else begin
         len = tap_count_ff[LW-1:0];
      end
   end

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign j_at_end  = (LW'(j_ff) == len - LW'(1));
   assign more_tail = last_ff && (CW'(d_ff) + CW'(3) <= CW'(len));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (!parity_ff || (req_chan.last_in && len >= LW'(2)))) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (j_at_end) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = more_tail ? ST_MAC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture window, advance or clear history and phase
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         for (int k = 0; k < MAX_TAPS - 1; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (req_fire) begin
         if (req_chan.last_in) begin
            parity_ff <= 1'b0;
            for (int k = 0; k < MAX_TAPS - 1; k++) begin
               hist_ff[k] <= '0;
            end
         end else begin
            parity_ff  <= !parity_ff;
            hist_ff[0] <= req_chan.sample;
            for (int k = 1; k < MAX_TAPS - 1; k++) begin
               hist_ff[k] <= hist_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         win_ff[0] <= req_chan.sample;
         for (int k = 1; k < MAX_TAPS; k++) begin
            win_ff[k] <= hist_ff[k-1];
         end
         last_ff <= req_chan.last_in;
         d_ff    <= IW'(parity_ff);
         j_ff    <= IW'(parity_ff);
      end else if (state_ff == ST_MAC) begin
         j_ff <= j_ff + IW'(1);
      end else if (state_ff == ST_OUT && out_free && more_tail) begin
         d_ff <= d_ff + IW'(2);
         j_ff <= d_ff + IW'(2);
      end
   end

   // issue one tap a cycle to the shared MAC
   assign mac_ctl.valid = (state_ff == ST_MAC);
   assign mac_ctl.first = (j_ff == d_ff);
   assign mac_ctl.last  = j_at_end;

   dfir2_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coef  (tap_arr[j_ff]),
      .smp   (win_ff[j_ff - d_ff]),
      .acc   (mac_acc),
      .done  (mac_done)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_value_ff <= mac_acc;
         rsp_last_ff  <= last_ff && !more_tail;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_value = rsp_value_ff;
   assign rsp_chan.last_out       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_WAIT)
      else $error("MAC result arrived outside the wait state");

   a_odd_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && parity_ff && !req_chan.last_in) |=> state_ff == ST_IDLE)
      else $error("odd sample started a result");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.last_in) |=> !parity_ff)
      else $error("phase not cleared after last sample");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_valid_ff)
      else $error("result load did not present an item");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimating FIR unit.
// ----------------------------------------------------------------------------
// Sample vectors go in through the request channel, and each filtered value
// that comes out is compared with a local model of the filter or a typed
// row's value. The model keeps its own sample history, phase and register
// copies. A short list of directed rows covers reset values, full-scale
// samples and taps, out-of-range tap counts, odd and even vector ends and
// the widest tail flush. Random phases of register settings and vectors
// follow. Both channels stall at random, except near the end of the run.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIR_TAPS     = 8;
   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 380;
   localparam int CALM_AFTER   = 340;
   localparam int TAIL_CYCLES  = 64;

   // index that maps to no register; writes to it must change nothing
   localparam logic [dfir2_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [dfir2_pkg::CSR_IDX_W-1:0]     index;
      logic [dfir2_pkg::CSR_DATA_W-1:0]    data;
      dfir2_pkg::sample_type               sample;
      logic                                last;
      bit                                  typed;
      dfir2_pkg::acc_type                  want_value;
      logic                                want_last;
   } stim_row_type;

   typedef struct {
      dfir2_pkg::acc_type value;
      logic               last;
   } fir_out_type;

   logic clock = 1'b0;
   logic reset;

   dfir2_req_if req_chan();
   dfir2_rsp_if rsp_chan();
   dfir2_csr_if csr_chan();

   decimating_fir_by_two_unit #(.MAX_TAPS(FIR_TAPS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // filter model state and register copies
   logic [dfir2_pkg::TAP_COUNT_W-1:0] shadow_tap_count;
   logic [dfir2_pkg::COEF_REG_W-1:0]  shadow_coef_lo;
   logic [dfir2_pkg::COEF_REG_W-1:0]  shadow_coef_hi;
   dfir2_pkg::sample_type             history [FIR_TAPS-1];
   logic                              odd_position;

   fir_out_type pending_outputs[$];
   fir_out_type step_outputs[$];

   int errors           = 0;
   int samples_sent     = 0;
   int vectors_sent     = 0;
   int outputs_checked  = 0;
   int registers_written = 0;
   bit calm             = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // filter model
   // ------------------------------------------------------------------------
   function automatic longint tap_weight(int j);
      logic [dfir2_pkg::COEF_REG_W-1:0] bank;
      dfir2_pkg::coef_type              w;
      bank = (j < 4) ? shadow_coef_lo : shadow_coef_hi;
      w = bank[(j % 4) * dfir2_pkg::COEF_W +: dfir2_pkg::COEF_W];
      return longint'(w);
   endfunction

   // Work out the filtered values one sample causes, then advance history.
   function automatic void filter_sample(dfir2_pkg::sample_type s, logic last_flag);
      longint      window [FIR_TAPS];
      longint      sum;
      int          taps;
      fir_out_type one;
      step_outputs.delete();
      if (shadow_tap_count == 0)
         taps = 1;
      else if (shadow_tap_count > FIR_TAPS)
         taps = FIR_TAPS;
      else
         taps = int'(shadow_tap_count);
      window[0] = longint'(s);
      for (int i = 1; i < FIR_TAPS; i++)
         window[i] = longint'(history[i-1]);
      // offset 0 only on even positions; larger offsets are the tail flush
      for (int d = odd_position ? 1 : 0; d < taps; d += 2) begin
         if (d > 0 && !last_flag)
            break;
         sum = 0;
         for (int j = d; j < taps; j++)
            sum += tap_weight(j) * window[j-d];
         one.value = sum[dfir2_pkg::ACC_W-1:0];
         one.last  = 1'b0;
         step_outputs.push_back(one);
      end
      if (last_flag) begin
         if (step_outputs.size() > 0)
            step_outputs[step_outputs.size()-1].last = 1'b1;
         for (int i = 0; i < FIR_TAPS-1; i++)
            history[i] = '0;
         odd_position = 1'b0;
      end else begin
         for (int i = FIR_TAPS-2; i > 0; i--)
            history[i] = history[i-1];
         history[0] = s;
         odd_position = ~odd_position;
      end
   endfunction

   // ------------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      errors++;
      $display("tb: @%0t mismatch: %s", $time, what);
   endtask

   function automatic stim_row_type typed_row(dfir2_pkg::sample_type s, logic l,
                                              dfir2_pkg::acc_type v, logic vl);
      stim_row_type r;
      r.kind       = ROW_SAMPLE;
      r.index      = dfir2_pkg::CSR_TAP_COUNT;
      r.data       = '0;
      r.sample     = s;
      r.last       = l;
      r.typed      = 1'b1;
      r.want_value = v;
      r.want_last  = vl;
      return r;
   endfunction

   function automatic stim_row_type sample_row(dfir2_pkg::sample_type s, logic l);
      stim_row_type r;
      r = typed_row(s, l, '0, 1'b0);
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic stim_row_type write_row(logic [dfir2_pkg::CSR_IDX_W-1:0] idx,
                                              logic [dfir2_pkg::CSR_DATA_W-1:0] value);
      stim_row_type r;
      r = sample_row('0, 1'b0);
      r.kind  = ROW_WRITE;
      r.index = idx;
      r.data  = value;
      return r;
   endfunction

   function automatic logic [dfir2_pkg::CSR_DATA_W-1:0] pick_coef_bank();
      case ($urandom_range(0, 7))
         0:       return {4{16'h7FFF}};
         1:       return {4{16'h8000}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic dfir2_pkg::sample_type pick_sample();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      return dfir2_pkg::sample_type'($urandom);
   endfunction

   // Write one register; hold valid high when another write follows at once.
   task automatic write_register(input logic [dfir2_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [dfir2_pkg::CSR_DATA_W-1:0] value,
                                 input bit more);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      case (idx)
         dfir2_pkg::CSR_TAP_COUNT:
            shadow_tap_count = value[dfir2_pkg::TAP_COUNT_W-1:0];
         dfir2_pkg::CSR_COEF_TAPS_LO: shadow_coef_lo = value;
         dfir2_pkg::CSR_COEF_TAPS_HI: shadow_coef_hi = value;
         default: ;
      endcase
      registers_written++;
      if (!more)
         csr_chan.valid <= 1'b0;
   endtask

   // Send one sample item and queue the filtered values it causes.
   task automatic send_sample(input dfir2_pkg::sample_type s, input logic last_flag,
                              input bit typed, input dfir2_pkg::acc_type want_value,
                              input logic want_last);
      fir_out_type typed_out;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.sample  <= s;
      req_chan.last_in <= last_flag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      filter_sample(s, last_flag);
      if (typed) begin
         typed_out.value = want_value;
         typed_out.last  = want_last;
         pending_outputs.push_back(typed_out);
      end else begin
         foreach (step_outputs[k])
            pending_outputs.push_back(step_outputs[k]);
      end
      samples_sent++;
      if (last_flag)
         vectors_sent++;
   endtask

   // Hold off the sender until every queued value is out, then maybe let the
   // unit finish work that produces no value.
   task automatic settle_outputs(input bit with_pause);
      if (pending_outputs.size() != 0 || with_pause) begin
         req_chan.valid <= 1'b0;
         while (pending_outputs.size() != 0)
            @(posedge clock);
         if (with_pause && !calm)
            repeat (TAIL_CYCLES) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // result side: stall in bursts, check each accepted item
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
               stall = $urandom_range(1, 9);
         end
      end
   end

   always @(posedge clock) begin
      fir_out_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected item, filtered_value %0d last_out %b",
                                      rsp_chan.filtered_value, rsp_chan.last_out));
         end else begin
            want = pending_outputs.pop_front();
            outputs_checked++;
            if (rsp_chan.filtered_value !== want.value)
               report_mismatch($sformatf("filtered_value %0d, expected %0d",
                                         rsp_chan.filtered_value, want.value));
            if (rsp_chan.last_out !== want.last)
               report_mismatch($sformatf("last_out %b, expected %b",
                                         rsp_chan.last_out, want.last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      stim_row_type                     rows[$];
      logic [dfir2_pkg::CSR_DATA_W-1:0] value;
      int                               random_sent;
      int                               vec_count;
      int                               vec_len;
      bit                               fresh;
      bit                               leave_open;

      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.sample  <= '0;
      req_chan.last_in <= 1'b0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= dfir2_pkg::CSR_TAP_COUNT;
      csr_chan.data    <= '0;
      shadow_tap_count = 4'd1;
      shadow_coef_lo   = '0;
      shadow_coef_hi   = '0;
      for (int i = 0; i < FIR_TAPS-1; i++)
         history[i] = '0;
      odd_position = 1'b0;

      // reset values: one tap of zero, even-length vector ends with no value
      rows.push_back(typed_row(16'sh7FFF, 1'b0, 35'sd0, 1'b0));
      rows.push_back(sample_row(16'sh8000, 1'b1));
      // single tap of one, full-scale samples
      rows.push_back(write_row(dfir2_pkg::CSR_COEF_TAPS_LO, 64'h0000_0000_0000_4000));
      rows.push_back(typed_row(16'sh7FFF, 1'b1, 35'sd536854528, 1'b1));
      rows.push_back(typed_row(16'sh8000, 1'b1, -35'sd536870912, 1'b1));
      // tap count of zero acts as one
      rows.push_back(write_row(dfir2_pkg::CSR_TAP_COUNT, 64'd0));
      rows.push_back(typed_row(16'sh1234, 1'b1, 35'sd76349440, 1'b1));
      // all taps at the negative extreme, tap count above range acts as eight
      rows.push_back(write_row(dfir2_pkg::CSR_COEF_TAPS_LO, {4{16'h8000}}));
      rows.push_back(write_row(dfir2_pkg::CSR_COEF_TAPS_HI, {4{16'h8000}}));
      rows.push_back(write_row(dfir2_pkg::CSR_TAP_COUNT, 64'd15));
      rows.push_back(typed_row(16'sh8000, 1'b0, 35'sd1073741824, 1'b0));
      for (int k = 0; k < 7; k++)
         rows.push_back(sample_row(16'sh8000, 1'b0));
      rows.push_back(sample_row(16'sh8000, 1'b1));
      rows.push_back(sample_row(16'sh7FFF, 1'b1));
      // mixed taps, even-length end flushes four values
      rows.push_back(write_row(dfir2_pkg::CSR_TAP_COUNT, 64'd8));
      rows.push_back(write_row(dfir2_pkg::CSR_COEF_TAPS_LO, 64'h7FFF_0001_FFFF_C000));
      rows.push_back(write_row(dfir2_pkg::CSR_COEF_TAPS_HI, 64'h0000_8000_7FFF_2000));
      rows.push_back(sample_row(16'sh0001, 1'b0));
      rows.push_back(sample_row(16'shFFFF, 1'b1));
      // two taps, odd length
      rows.push_back(write_row(dfir2_pkg::CSR_TAP_COUNT, 64'd2));
      rows.push_back(sample_row(16'sh5555, 1'b0));
      rows.push_back(sample_row(16'shAAAA, 1'b0));
      rows.push_back(sample_row(16'sh0000, 1'b1));
      // unused index changes nothing; nine acts as eight
      rows.push_back(write_row(CSR_SPARE, '1));
      rows.push_back(write_row(dfir2_pkg::CSR_TAP_COUNT, 64'd9));
      rows.push_back(sample_row(16'sh4000, 1'b1));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the directed rows; drain before any register write
      fresh = 1'b0;
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE) begin
            if (fresh)
               settle_outputs(1'b1);
            fresh = 1'b0;
            write_register(rows[i].index, rows[i].data,
                           i + 1 < rows.size() && rows[i+1].kind == ROW_WRITE);
         end else begin
            send_sample(rows[i].sample, rows[i].last, rows[i].typed,
                        rows[i].want_value, rows[i].want_last);
            fresh = 1'b1;
         end
      end

      // random phases: new settings, then a few vectors
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle_outputs(1'b1);
         value = {$urandom, $urandom};
         value[dfir2_pkg::TAP_COUNT_W-1:0] = ($urandom_range(0, 3) == 0) ?
            dfir2_pkg::TAP_COUNT_W'($urandom_range(0, 15)) :
            dfir2_pkg::TAP_COUNT_W'($urandom_range(1, 8));
         write_register(dfir2_pkg::CSR_TAP_COUNT, value, 1'b1);
         write_register(dfir2_pkg::CSR_COEF_TAPS_LO, pick_coef_bank(), 1'b1);
         if ($urandom_range(0, 5) == 0) begin
            write_register(dfir2_pkg::CSR_COEF_TAPS_HI, pick_coef_bank(), 1'b1);
            write_register(CSR_SPARE, {$urandom, $urandom}, 1'b0);
         end else begin
            write_register(dfir2_pkg::CSR_COEF_TAPS_HI, pick_coef_bank(), 1'b0);
         end

         vec_count  = $urandom_range(1, 4);
         leave_open = ($urandom_range(0, 9) == 0);
         for (int v = 0; v < vec_count; v++) begin
            vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) :
                                                     $urandom_range(1, 10);
            for (int k = 0; k < vec_len; k++) begin
               if (!calm && $urandom_range(0, 24) == 0)
                  settle_outputs(1'b0);
               send_sample(pick_sample(),
                           k == vec_len-1 && !(leave_open && v == vec_count-1),
                           1'b0, '0, 1'b0);
               random_sent++;
               calm = (random_sent >= CALM_AFTER);
            end
         end
      end

      settle_outputs(1'b1);
      $display("tb: %0d samples in %0d closed vectors, %0d filtered values compared",
               samples_sent, vectors_sent, outputs_checked);
      $display("tb: %0d register writes, %0d mismatches", registers_written, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hard limit on run time
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
